[src/rqo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report queue package
// Shared constants, codes and types of the report queue with overflow policy.
// ----------------------------------------------------------------------------
package rqo_pkg;

  localparam int DEPTH        = 16;
  localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int VALUE_W      = 64;
  localparam int STATUS_W     = 32;
  localparam int INDEX_OUT_W  = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [STATUS_W-1:0] OVERFLOW_BIT = 32'h0000_0480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUEUE_SIZE     = 2'd0,
    CFG_DISCARD_OLDEST = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_TAKE    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic mark_wr;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic need_rd;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] written_index;
    logic [INDEX_OUT_W-1:0] marked_index;
    logic                   overflow_marked;
    logic [INDEX_OUT_W-1:0] entries;
    logic                   pending;
    logic                   overflow_seen;
    logic [VALUE_W-1:0]     out_value;
    logic [STATUS_W-1:0]    out_status;
    logic                   out_valid;
  } out_item_t;

endpackage

[src/rqo_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report queue channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rqo_in_if;
  import rqo_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status_word;

  modport source (output valid, op, value, status_word, input ready);
  modport sink (input valid, op, value, status_word, output ready);
endinterface

interface rqo_out_if;
  import rqo_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [INDEX_OUT_W-1:0] written_index;
  logic [INDEX_OUT_W-1:0] marked_index;
  logic                   overflow_marked;
  logic [INDEX_OUT_W-1:0] entries;
  logic                   pending;
  logic                   overflow_seen;
  logic [VALUE_W-1:0]     out_value;
  logic [STATUS_W-1:0]    out_status;
  logic                   out_valid;

  modport source (
    output valid, written_index, marked_index, overflow_marked, entries, pending,
           overflow_seen, out_value, out_status, out_valid,
    input  ready
  );
  modport sink (
    input  valid, written_index, marked_index, overflow_marked, entries, pending,
           overflow_seen, out_value, out_status, out_valid,
    output ready
  );
endinterface

[src/rqo_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report queue controller
// Sequences accept, execute, slot read/mark and result hand-off of one request.
// ----------------------------------------------------------------------------
module rqo_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rqo_pkg::stat_t stat_i,
  output rqo_pkg::cmd_t  cmd_o
);
  import rqo_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = stat_i.need_rd ? S_READ : S_FIN;
      end
      S_READ: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_READ: cmd_o.mark_wr = 1'b1;
      S_FIN:  cmd_o.res_load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !stat_i.out_free) |=> (state_q == S_FIN))
    else $error("controller left the finish state with the result register busy");

  a_read_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ($past(state_q) == S_EXEC))
    else $error("slot read state entered without an execute step");

  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_EXEC))
    else $error("accepted request was not executed");

endmodule

[src/rqo_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report queue datapath
// Configuration, ring pointers, slot memory and the result register.
// ----------------------------------------------------------------------------
module rqo_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rqo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rqo_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_op_i,
  input  logic [rqo_pkg::VALUE_W-1:0]      in_value_i,
  input  logic [rqo_pkg::STATUS_W-1:0]     in_status_i,
  input  rqo_pkg::cmd_t                    cmd_i,
  output rqo_pkg::stat_t                   stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output rqo_pkg::out_item_t               out_item_o
);
  import rqo_pkg::*;

  function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] j;
    j = (CNT_W + 1)'(i) + (CNT_W + 1)'(1);
    return (j >= (CNT_W + 1)'(n)) ? '0 : j[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] last;
    last = n - CNT_W'(1);
    return (i == '0) ? last[IDX_W-1:0] : i - IDX_W'(1);
  endfunction

  logic [CFG_DATA_W-1:0] qsize_q;
  logic                  discard_q;

  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  ovf_q, ovf_d;

  logic                  op_q;
  logic [VALUE_W-1:0]    value_q;
  logic [STATUS_W-1:0]   status_q;

  logic [VALUE_W-1:0]    value_mem [DEPTH];
  logic [STATUS_W-1:0]   status_mem [DEPTH];
  logic [VALUE_W-1:0]    rd_value_q;
  logic [STATUS_W-1:0]   rd_status_q;

  logic                  rmw_q, rmw_d;
  logic [IDX_W-1:0]      res_written_q, res_written_d;
  logic [IDX_W-1:0]      res_marked_q, res_marked_d;
  logic                  res_mark_q, res_mark_d;
  logic                  res_valid_q, res_valid_d;

  logic                  out_valid_q;
  out_item_t             out_item_q;

  logic [CNT_W-1:0]      size_n;
  logic [IDX_W-1:0]      head_c, tail_c, head_adv, newest;
  logic [CNT_W-1:0]      count_c;
  logic                  full;
  logic                  we_val, we_st;
  logic [IDX_W-1:0]      wr_addr;
  logic [STATUS_W-1:0]   wr_status;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qsize_q   <= CFG_DATA_W'(1);
      discard_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_QUEUE_SIZE:     qsize_q <= cfg_data_i;
        CFG_DISCARD_OLDEST: discard_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (qsize_q == '0) begin
      size_n = CNT_W'(1);
    end else if (qsize_q > CFG_DATA_W'(DEPTH)) begin
      size_n = CNT_W'(DEPTH);
    end else begin
      size_n = qsize_q[CNT_W-1:0];
    end
    head_c   = (CNT_W'(head_q) >= size_n) ? '0 : head_q;
    tail_c   = (CNT_W'(tail_q) >= size_n) ? '0 : tail_q;
    count_c  = (count_q > size_n) ? size_n : count_q;
    full     = (count_c >= size_n);
    head_adv = step_fwd(head_c, size_n);
    newest   = step_back(tail_c, size_n);
  end

  always_comb begin
    head_d        = head_c;
    tail_d        = tail_c;
    count_d       = count_c;
    ovf_d         = ovf_q;
    we_val        = 1'b0;
    we_st         = 1'b0;
    wr_addr       = tail_c;
    wr_status     = status_q;
    rd_en         = 1'b0;
    rd_addr       = head_c;
    rmw_d         = 1'b0;
    res_written_d = '0;
    res_marked_d  = '0;
    res_mark_d    = 1'b0;
    res_valid_d   = 1'b0;
    if (op_q == OP_ENQUEUE) begin
      we_val = 1'b1;
      we_st  = 1'b1;
      if (!full) begin
        res_written_d = tail_c;
        tail_d        = step_fwd(tail_c, size_n);
        count_d       = count_c + CNT_W'(1);
      end else if (discard_q) begin
        head_d        = head_adv;
        res_written_d = tail_c;
        tail_d        = step_fwd(tail_c, size_n);
        res_marked_d  = head_adv;
        res_mark_d    = 1'b1;
        ovf_d         = 1'b1;
        if (head_adv == tail_c) begin
          wr_status = status_q | OVERFLOW_BIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_adv;
          rmw_d   = 1'b1;
        end
      end else begin
        wr_addr       = newest;
        wr_status     = status_q | OVERFLOW_BIT;
        res_written_d = newest;
        res_marked_d  = newest;
        res_mark_d    = 1'b1;
        ovf_d         = 1'b1;
      end
    end else if (count_c != '0) begin
      rd_en       = 1'b1;
      rd_addr     = head_c;
      res_valid_d = 1'b1;
      head_d      = head_adv;
      count_d     = count_c - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= in_op_i;
      value_q  <= in_value_i;
      status_q <= in_status_i;
    end
    if (cmd_i.exec) begin
      rmw_q         <= rmw_d;
      res_written_q <= res_written_d;
      res_marked_q  <= res_marked_d;
      res_mark_q    <= res_mark_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we_val) begin
      value_mem[wr_addr] <= value_q;
    end
    if (cmd_i.exec && we_st) begin
      status_mem[wr_addr] <= wr_status;
    end else if (cmd_i.mark_wr && rmw_q) begin
      status_mem[res_marked_q] <= rd_status_q | OVERFLOW_BIT;
    end
    if (cmd_i.exec && rd_en) begin
      rd_value_q  <= value_mem[rd_addr];
      rd_status_q <= status_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_item_q.written_index   <= INDEX_OUT_W'(res_written_q);
      out_item_q.marked_index    <= INDEX_OUT_W'(res_marked_q);
      out_item_q.overflow_marked <= res_mark_q;
      out_item_q.entries         <= INDEX_OUT_W'(count_q);
      out_item_q.pending         <= (count_q != '0);
      out_item_q.overflow_seen   <= ovf_q;
      out_item_q.out_value       <= res_valid_q ? rd_value_q : '0;
      out_item_q.out_status      <= res_valid_q ? rd_status_q : '0;
      out_item_q.out_valid       <= res_valid_q;
    end
  end

  assign stat_o.need_rd  = rd_en;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds the ring depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(head_q) < CNT_W'(DEPTH)) && (CNT_W'(tail_q) < CNT_W'(DEPTH)))
    else $error("ring pointer outside the slot memory");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before its transaction");

  a_rmw_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && rmw_d) |-> (rd_addr != wr_addr))
    else $error("overflow mark read collides with the enqueue write");

endmodule

[src/report_queue_with_overflow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report queue with overflow policy
// Ring of value/status reports with discard-oldest or overwrite-newest policy.
// ----------------------------------------------------------------------------
// Sequence: each request passes the accept, execute and result-load steps; a
//   take or an oldest-discard mark that reads the slot adds the slot read and
//   status mark step, and result-load waits for a free result register.
// Requests: a new request is accepted only after the previous one has left
//   the result-load step, so requests never overlap.
// Reset: pointers, count, overflow flag and control clear; queue size resets
//   to 1 and the discard-oldest policy is selected. Slot contents are not reset.
module report_queue_with_overflow (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rqo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rqo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rqo_in_if.sink                         in_if,
  rqo_out_if.source                      out_if
);
  import rqo_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  out_item_t out_item;

  rqo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rqo_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (in_if.op),
    .in_value_i  (in_if.value),
    .in_status_i (in_if.status_word),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_item_o  (out_item)
  );

  assign out_if.written_index   = out_item.written_index;
  assign out_if.marked_index    = out_item.marked_index;
  assign out_if.overflow_marked = out_item.overflow_marked;
  assign out_if.entries         = out_item.entries;
  assign out_if.pending         = out_item.pending;
  assign out_if.overflow_seen   = out_item.overflow_seen;
  assign out_if.out_value       = out_item.out_value;
  assign out_if.out_status      = out_item.out_status;
  assign out_if.out_valid       = out_item.out_valid;

endmodule
